// File: src/abl_pkg.sv
`default_nettype none
package abl_pkg;

    localparam int SAMPLE_W = 16;
    localparam int STATE_W  = 32;
    localparam int ENERGY_W = 48;
    localparam int TALLY_W  = 14;
    localparam int FREQ_W   = 17;
    localparam int DAMP_W   = 22;
    localparam int GAIN_W   = 26;
    localparam int SLOT_W   = 9;
    localparam int CFG_W    = 26;
    localparam int IDX_W    = 3;

    localparam logic [IDX_W-1:0] REG_BAND_MODE = 3'd0;
    localparam logic [IDX_W-1:0] REG_COEF_FREQ = 3'd1;
    localparam logic [IDX_W-1:0] REG_COEF_DAMP = 3'd2;
    localparam logic [IDX_W-1:0] REG_GAIN      = 3'd3;
    localparam logic [IDX_W-1:0] REG_DMX_SLOT  = 3'd4;

    // Shared-multiplier operation codes
    typedef enum logic [2:0] {
        MUL_DAMP,   // r * band
        MUL_HP,     // w * hp
        MUL_LOW,    // w * band(new)
        MUL_SQ,     // v * v
        MUL_GAIN    // rms22 * gain
    } mul_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DAMP,
        ST_HP,
        ST_WHP,     // issue w * hp from the registered hp
        ST_LOW,
        ST_WLOW,    // issue w * band from the registered new band
        ST_SQ,
        ST_ACC,
        ST_DIV,
        ST_SQRT,
        ST_GAIN,
        ST_OUT
    } state_t;

    function automatic logic signed [STATE_W-1:0] sat32(input logic signed [49:0] v);
        if (v > 50'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -50'sh0_8000_0000) return 32'sh8000_0000;
        return v[STATE_W-1:0];
    endfunction

endpackage
`default_nettype wire

// File: src/abl_mul.sv
`default_nettype none
module abl_mul
    import abl_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic signed [39:0] op_a,
    input  wire logic signed [26:0] op_b,
    output logic signed [66:0]      prod_reg
);
    // One registered signed multiplier, shared by every multiply step
    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end
endmodule
`default_nettype wire

// File: src/abl_divsqrt.sv
`default_nettype none
module abl_divsqrt
    import abl_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start_div,
    input  wire logic                start_sqrt,
    input  wire logic [ENERGY_W-1:0] dividend,
    input  wire logic [TALLY_W-1:0]  divisor,
    output logic                     done,
    output logic [31:0]              root_reg
);
    // Restoring divide, one quotient bit a cycle; then bitwise sqrt,
    // one result bit a cycle on mean * 2^14 (62 bits).
    logic [ENERGY_W-1:0] quo_reg, quo_next;
    logic [TALLY_W:0]    rem_reg, rem_next;
    logic [63:0]         rad_reg, rad_next;
    logic [32:0]         srem_reg, srem_next;
    logic [31:0]         root_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic                div_reg, div_next, sq_reg, sq_next;
    logic [TALLY_W:0]    trial_rem;
    logic [34:0]         trial_s;
    logic [34:0]         sub_s;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        rad_next  = rad_reg;
        srem_next = srem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        sq_next   = sq_reg;
        done      = 1'b0;
        trial_rem = {rem_reg[TALLY_W-1:0], quo_reg[ENERGY_W-1]};
        trial_s   = {srem_reg, rad_reg[63:62]};
        sub_s     = {1'b0, root_reg, 2'b01};
        if (start_div) begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = 6'd48;
            div_next = 1'b1;
        end else if (div_reg) begin
            if (trial_rem >= {1'b0, divisor}) begin
                rem_next = trial_rem - {1'b0, divisor};
                quo_next = {quo_reg[ENERGY_W-2:0], 1'b1};
            end else begin
                rem_next = trial_rem;
                quo_next = {quo_reg[ENERGY_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                div_next = 1'b0;
                done     = 1'b1;
            end
        end else if (start_sqrt) begin
            rad_next  = {2'b00, quo_reg[47:0], 14'd0};
            srem_next = '0;
            root_next = '0;
            cnt_next  = 6'd32;
            sq_next   = 1'b1;
        end else if (sq_reg) begin
            rad_next = {rad_reg[61:0], 2'b00};
            if (trial_s >= sub_s) begin
                srem_next = 33'(trial_s - sub_s);
                root_next = {root_reg[30:0], 1'b1};
            end else begin
                srem_next = trial_s[32:0];
                root_next = {root_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                sq_next = 1'b0;
                done    = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_reg <= 1'b0;
            sq_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            div_reg <= div_next;
            sq_reg  <= sq_next;
            cnt_reg <= cnt_next;
        end
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        rad_reg  <= rad_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
    end
endmodule
`default_nettype wire

// File: src/audio_band_level_to_dmx.sv
// Channel | Dir | tdata (low bit up)                             | tuser/tlast
// s_      | in  | sample[15:0]                                   | tuser=channel_sel, tlast=block_end
// m_      | out | slot_index[8:0], slot_byte[16:9], level[32:17] | -
// cfg     | in  | cfg_wr_en, cfg_index[2:0], cfg_data[25:0]      | -
// A sample passes IDLE, DAMP, HP, WHP, LOW, WLOW, SQ, ACC in band mode (three filter
// multiplies, square, accumulate; w * hp and w * band are each issued in the state
// after their operand is registered) and IDLE, SQ, ACC in RMS mode. All products share
// one 40x27 multiplier. Block end adds a restoring divide, a bitwise square root, one
// gain multiply and the output stage. Synchronous active-low reset; the result register
// holds while m_tready is low, and the next block end waits in the gain step until it frees.
`default_nettype none
module audio_band_level_to_dmx
    import abl_pkg::*;
#(
    parameter int MAX_BLOCK = 8192
)(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [15:0]        s_tdata,   // sample
    input  wire logic               s_tuser,   // channel_sel
    input  wire logic               s_tlast,   // block_end
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [39:0]             m_tdata,   // slot_index, slot_byte, level_frac
    input  wire logic               cfg_wr_en,
    input  wire logic [IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data
);
    localparam logic [TALLY_W-1:0] TALLY_CAP =
        TALLY_W'((MAX_BLOCK < 16383) ? MAX_BLOCK : 16383);
    localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

    state_t state_reg, state_next;

    logic              band_mode_reg;
    logic [FREQ_W-1:0] freq_reg;
    logic [DAMP_W-1:0] damp_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [SLOT_W-1:0] slot_reg;

    logic signed [STATE_W-1:0] low_reg [2];
    logic signed [STATE_W-1:0] band_reg [2];
    logic [ENERGY_W-1:0] energy_reg;
    logic [TALLY_W-1:0]  tally_reg;

    logic signed [SAMPLE_W-1:0] samp_reg;
    logic chan_reg, last_reg;
    logic signed [STATE_W-1:0] nband_reg;
    logic signed [39:0] hp_reg;
    logic [39:0] out_reg;
    logic        ovalid_reg;

    mul_op_t op;
    logic signed [39:0] op_a;
    logic signed [26:0] op_b;
    logic signed [66:0] prod_reg;
    logic div_done;
    logic [31:0] root;
    logic start_div, start_sqrt;

    abl_mul u_mul (.aclk, .op_a, .op_b, .prod_reg);
    abl_divsqrt u_ds (
        .aclk, .aresetn, .start_div, .start_sqrt,
        .dividend(energy_reg), .divisor(tally_reg),
        .done(div_done), .root_reg(root)
    );

    // rnd16 on a product
    function automatic logic signed [49:0] rnd16(input logic signed [66:0] p);
        logic signed [66:0] a;
        a = p + 67'sd32768;
        return 50'(a >>> 16);
    endfunction

    logic signed [STATE_W-1:0] cur_low, cur_band;
    logic signed [19:0] vband;
    logic signed [19:0] vmeas;
    logic ds_run_reg;
    logic signed [STATE_W:0] rnd_b;

    assign cur_low  = low_reg[chan_reg];
    assign cur_band = band_reg[chan_reg];
    assign rnd_b    = {nband_reg[STATE_W-1], nband_reg} + 33'sd4096;
    assign vband    = 20'(rnd_b >>> 13);
    assign vmeas    = band_mode_reg ? vband : 20'(samp_reg);

    always_comb begin
        unique case (state_reg)
            ST_DAMP: op = MUL_DAMP;
            ST_WHP:  op = MUL_HP;
            ST_WLOW: op = MUL_LOW;
            ST_GAIN: op = MUL_GAIN;
            default: op = MUL_SQ;
        endcase
        unique case (op)
            MUL_DAMP: begin op_a = 40'(cur_band); op_b = 27'($signed({1'b0, damp_reg})); end
            MUL_HP:   begin op_a = hp_reg; op_b = 27'($signed({1'b0, freq_reg})); end
            MUL_LOW:  begin op_a = 40'(nband_reg); op_b = 27'($signed({1'b0, freq_reg})); end
            MUL_GAIN: begin op_a = 40'($signed({1'b0, root}));
                            op_b = $signed({1'b0, gain_reg}); end
            default:  begin op_a = 40'(vmeas); op_b = 27'(vmeas); end
        endcase
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = ovalid_reg;
    assign m_tdata   = out_reg;

    logic take;
    assign take = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (take) state_next = (band_mode_reg) ? ST_DAMP : ST_SQ;
            ST_DAMP: state_next = ST_HP;
            ST_HP:   state_next = ST_WHP;
            ST_WHP:  state_next = ST_LOW;
            ST_LOW:  state_next = ST_WLOW;
            ST_WLOW: state_next = ST_SQ;
            ST_SQ:   state_next = ST_ACC;
            ST_ACC:  state_next = !last_reg ? ST_IDLE : ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_SQRT;
            ST_SQRT: if (div_done) state_next = ST_GAIN;
            // wait here while the previous result is still held
            ST_GAIN: if (!ovalid_reg || m_tready) state_next = ST_OUT;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        start_div  = (state_reg == ST_DIV) && !ds_run_reg;
        start_sqrt = (state_reg == ST_SQRT) && !ds_run_reg;
    end

    logic signed [49:0] hp_full, nb_full, nl_full;
    logic [ENERGY_W-1:0] sq_u;
    logic [16:0] lvl;
    logic [25:0] byte_full;
    assign hp_full = 50'(samp_reg) * 50'sd8192 - rnd16(prod_reg) - 50'(cur_low);
    assign nb_full = 50'(cur_band) + rnd16(prod_reg);
    assign nl_full = 50'(cur_low) + rnd16(prod_reg);
    assign sq_u    = prod_reg[ENERGY_W-1:0];
    assign lvl = (tally_reg == '0) ? 17'd0 :
                 (prod_reg >= 67'sh40_0000_0000) ? 17'd65536 :
                 17'((prod_reg + 67'sd2097152) >>> 22);
    assign byte_full = 26'(lvl) * 26'd255 + 26'd32768;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            band_mode_reg  <= 1'b1;
            freq_reg       <= 17'd5904;
            damp_reg       <= 22'd186526;
            gain_reg       <= 26'd655360;
            slot_reg       <= '0;
            low_reg[0]     <= '0;
            low_reg[1]     <= '0;
            band_reg[0]    <= '0;
            band_reg[1]    <= '0;
            energy_reg     <= '0;
            tally_reg      <= '0;
            ovalid_reg     <= 1'b0;
            ds_run_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (ovalid_reg && m_tready) ovalid_reg <= 1'b0;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_BAND_MODE: band_mode_reg <= cfg_data[0];
                    REG_COEF_FREQ, REG_COEF_DAMP: begin
                        if (cfg_index == REG_COEF_FREQ) freq_reg <= cfg_data[FREQ_W-1:0];
                        else damp_reg <= cfg_data[DAMP_W-1:0];
                        low_reg[0]  <= '0;
                        low_reg[1]  <= '0;
                        band_reg[0] <= '0;
                        band_reg[1] <= '0;
                    end
                    REG_GAIN:     gain_reg <= cfg_data[GAIN_W-1:0];
                    REG_DMX_SLOT: slot_reg <= cfg_data[SLOT_W-1:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_HP:  hp_reg <= 40'(hp_full);
                ST_LOW: begin
                    nband_reg          <= sat32(nb_full);
                    band_reg[chan_reg] <= sat32(nb_full);
                end
                ST_SQ: if (band_mode_reg) low_reg[chan_reg] <= sat32(nl_full);
                ST_ACC: begin
                    if (tally_reg < TALLY_CAP) begin
                        energy_reg <= (sq_u > ENERGY_MAX - energy_reg) ? ENERGY_MAX
                                                                       : energy_reg + sq_u;
                        tally_reg  <= tally_reg + 1'b1;
                    end
                end
                ST_DIV, ST_SQRT: ds_run_reg <= !div_done;
                ST_OUT: begin
                    out_reg    <= {7'd0, (lvl > 17'd65535) ? 16'hFFFF : lvl[15:0],
                                   byte_full[23:16], slot_reg};
                    ovalid_reg <= 1'b1;
                    energy_reg <= '0;
                    tally_reg  <= '0;
                end
                default: ;
            endcase
            if (take) begin
                samp_reg <= s_tdata;
                chan_reg <= s_tuser;
                last_reg <= s_tlast;
            end
        end
    end

    // Hold the result until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_OUT |-> !m_tvalid)
        else $error("pending result overwritten");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_OUT |=> tally_reg == '0 && energy_reg == '0)
        else $error("block sum not cleared");
endmodule
`default_nettype wire
